[hdl/fwsl_pkg.sv]
// ----------------------------------------------------------------------------
// fwsl_pkg: shared types, constants and tables of the steer command limiter
// payload structs, config register indexes, cordic angle table
// ----------------------------------------------------------------------------
`default_nettype none
package fwsl_pkg;

  localparam int FracBitsDef    = 12;
  localparam int CordicStepsDef = 14;
  localparam int GuardFrac      = 30;
  localparam int CfgW           = 15;
  localparam int CfgIdxW        = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_SPEED   = 3'd0,
    CFG_FLOOR_SPEED = 3'd1,
    CFG_INCLINE     = 3'd2,
    CFG_TAN_MAX     = 3'd3,
    CFG_HALF_BASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] speed_req;
    logic signed [15:0] curvature_req;
    logic signed [15:0] lateral_tan_req;
    logic signed [15:0] inclination;
  } cmd_in_t;

  typedef struct packed {
    logic signed [15:0] speed_out;
    logic signed [15:0] front_angle;
    logic signed [15:0] rear_angle;
    logic               curv_clamped;
    logic               angles_fresh;
  } cmd_out_t;

  typedef struct packed {
    logic [CfgW-1:0] max_speed;
    logic [CfgW-1:0] floor_speed;
    logic [CfgW-1:0] incline;
    logic [CfgW-1:0] tan_max;
    logic [CfgW-1:0] half_base;
  } cfg_t;

  // classified job handed from front to back
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] kappa;
    logic signed [15:0] tang;
    logic               clamped;
    logic               fresh;
  } job_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/fwsl_front.sv]
// ----------------------------------------------------------------------------
// fwsl_front: speed limiting and curvature / tangent classification
// sequenced by a state machine, one shared multiplier, serial divider for limit
// ----------------------------------------------------------------------------
`default_nettype none
module fwsl_front #(
  parameter int FracBits = fwsl_pkg::FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fwsl_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fwsl_pkg::cmd_in_t in_data_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output fwsl_pkg::job_t        job_o
);
  import fwsl_pkg::*;

  localparam int DivW = CfgW + FracBits;       // dividend width
  localparam int CntW = $clog2(DivW + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INCL = 7'b0000010,
    S_MAG  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_KB   = 7'b0010000,
    S_TAN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_e;

  st_e st_q, st_d;
  cmd_in_t cmd_q;
  logic signed [33:0] kf_q;        // 1 - incl*factor
  logic [DivW-1:0] quo_q;
  logic [CfgW:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic signed [33:0] mt_q;
  job_t job_q;
  logic [CfgW-1:0] hb;

  assign hb = (cfg_i.half_base == '0) ? CfgW'(1) : cfg_i.half_base;
  assign in_ready_o  = (st_q == S_IDLE);
  assign job_valid_o = (st_q == S_OUT);
  assign job_o       = job_q;

  // shared product, wide enough for full speed times the largest factor
  logic signed [35:0] prod;
  logic signed [16:0] mag_s;
  logic signed [16:0] mag_k;
  always_comb begin
    mag_s = cmd_q.speed_req[15] ? -17'(cmd_q.speed_req) : 17'(cmd_q.speed_req);
    mag_k = cmd_q.curvature_req[15] ? -17'(cmd_q.curvature_req)
                                    : 17'(cmd_q.curvature_req);
    case (st_q)
      S_INCL:  prod = 36'(cmd_q.inclination) * $signed({1'b0, cfg_i.incline});
      S_MAG:   prod = 36'(mag_s) * 36'(kf_q);
      S_KB:    prod = 36'(mag_k) * $signed({1'b0, hb});
      default: prod = '0;
    endcase
  end

  // speed clamps
  logic signed [33:0] im;
  logic signed [16:0] s_lim;
  always_comb begin
    im = (kf_q <= 0) ? 34'sd0 : 34'(prod >>> FracBits);
    s_lim = 17'(cmd_q.speed_req);
    if (cmd_q.speed_req > 0) begin
      if (s_lim > $signed({2'b0, cfg_i.max_speed})) s_lim = $signed({2'b0, cfg_i.max_speed});
      if (34'(s_lim) > im) s_lim = 17'(im);
      if (s_lim < $signed({2'b0, cfg_i.floor_speed})) s_lim = $signed({2'b0, cfg_i.floor_speed});
    end else if (cmd_q.speed_req < 0) begin
      if (s_lim < -$signed({2'b0, cfg_i.max_speed})) s_lim = -$signed({2'b0, cfg_i.max_speed});
      if (34'(s_lim) < -im) s_lim = 17'(-im);
      if (s_lim > -$signed({2'b0, cfg_i.floor_speed})) s_lim = -$signed({2'b0, cfg_i.floor_speed});
    end
  end

  // restoring division step for the curvature limit
  logic [CfgW+1:0] trial;
  logic [DivW-1:0] dvd;
  assign dvd = {cfg_i.tan_max, FracBits'(0)};
  assign trial = {rem_q, dvd[cnt_q[CntW-1:0] - CntW'(1)]} - {2'b0, hb};

  // tangent clamp and curvature decision
  logic signed [33:0] maxk;
  job_t nj;
  logic signed [33:0] tg;
  always_comb begin
    maxk = 34'($signed({1'b0, quo_q}));
    nj = job_q;
    tg = 34'(cmd_q.lateral_tan_req);
    if (34'(cmd_q.curvature_req) >= maxk) begin
      nj.kappa = 16'(maxk); nj.tang = '0; nj.clamped = 1'b1;
    end else if (34'(cmd_q.curvature_req) <= -maxk) begin
      nj.kappa = 16'(-maxk); nj.tang = '0; nj.clamped = 1'b1;
    end else begin
      if (tg > mt_q) tg = mt_q;
      if (tg < -mt_q) tg = -mt_q;
      nj.kappa = cmd_q.curvature_req; nj.tang = 16'(tg); nj.clamped = 1'b0;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_INCL;
      S_INCL: st_d = S_MAG;
      S_MAG:  st_d = (s_lim == '0) ? S_OUT : S_DIV;
      S_DIV:  if (cnt_q == CntW'(1)) st_d = S_KB;
      S_KB:   st_d = S_TAN;
      S_TAN:  st_d = S_OUT;
      S_OUT:  if (job_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cmd_q <= in_data_i;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CntW'(DivW);
      end
      S_INCL: kf_q <= (34'sd1 <<< FracBits) - 34'(prod >>> FracBits);
      S_MAG: begin
        job_q.speed <= 16'(s_lim);
        job_q.fresh <= (s_lim != '0);
        job_q.clamped <= 1'b0;
      end
      S_DIV: begin
        cnt_q <= cnt_q - CntW'(1);
        if (!trial[CfgW+1]) begin
          rem_q <= trial[CfgW:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[CfgW-1:0], dvd[cnt_q[CntW-1:0] - CntW'(1)]};
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
      end
      S_KB:  mt_q <= 34'($signed({21'b0, cfg_i.tan_max}) - (prod >>> FracBits));
      S_TAN: job_q <= nj;
      default: ;
    endcase
  end

  // a job leaves only with a nonzero speed when it is fresh
  a_fresh_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> (job_o.fresh == (job_o.speed != '0))) else $error("fresh mismatch");
  a_clamp_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_o.clamped) |-> job_o.fresh) else $error("clamp on held");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && !job_ready_i) |=> (job_valid_o && $stable(job_o)))
    else $error("job changed while stalled");

endmodule
`default_nettype wire

[hdl/fwsl_queue.sv]
// ----------------------------------------------------------------------------
// fwsl_queue: two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module fwsl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire fwsl_pkg::job_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output fwsl_pkg::job_t      rd_data_o
);
  import fwsl_pkg::*;

  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointer mismatch");
  a_empty_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> (cnt_q != 2'd2)) else $error("queue jumped");

endmodule
`default_nettype wire

[hdl/fwsl_back.sv]
// ----------------------------------------------------------------------------
// fwsl_back: steer angle computation with one iterative vectoring cordic
// computes front, then rear, holds angles when the job is not fresh
// ----------------------------------------------------------------------------
`default_nettype none
module fwsl_back #(
  parameter int FracBits    = fwsl_pkg::FracBitsDef,
  parameter int CordicSteps = fwsl_pkg::CordicStepsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fwsl_pkg::cfg_t   cfg_i,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire fwsl_pkg::job_t   job_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fwsl_pkg::cmd_out_t    out_data_o
);
  import fwsl_pkg::*;

  localparam int Steps = (CordicSteps < 24) ? CordicSteps : 24;
  // argument reaches about 2^19 in Q12, i.e. 2^37 with 30 fraction bits, plus gain
  localparam int W     = 42;
  localparam int IW    = 5;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_LOAD = 5'b00100,
    B_ITER = 5'b01000,
    B_DONE = 5'b10000
  } bst_e;

  bst_e st_q, st_d;
  job_t job_q;
  logic signed [33:0] kb_q;
  logic signed [W-1:0] x_q, y_q, z_q;
  logic [IW-1:0] i_q;
  logic rear_q;
  logic signed [15:0] front_q, rear_ang_q;
  logic out_valid_q;
  cmd_out_t out_q;
  logic [CfgW-1:0] hb;

  assign hb = (cfg_i.half_base == '0) ? CfgW'(1) : cfg_i.half_base;
  assign job_ready_o = (st_q == B_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic signed [33:0] kprod;
  assign kprod = 34'(job_q.kappa) * $signed({1'b0, hb});

  logic signed [33:0] arg;
  assign arg = (rear_q ? -34'(job_q.tang) : 34'(job_q.tang)) + kb_q;

  logic signed [W-1:0] dx, dy;
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;

  logic signed [W-1:0] zr;
  logic signed [15:0] ang;
  always_comb begin
    zr = (z_q + (W'(1) <<< (GuardFrac - FracBits - 1))) >>> (GuardFrac - FracBits);
    if (zr > W'(32767)) ang = 16'sh7FFF;
    else if (zr < -W'(32768)) ang = -16'sh8000;
    else ang = 16'(zr);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: if (job_valid_i && job_ready_o) st_d = B_MUL;
      B_MUL:  st_d = job_q.fresh ? B_LOAD : B_DONE;
      B_LOAD: st_d = B_ITER;
      B_ITER: if (i_q == IW'(Steps - 1)) st_d = rear_q ? B_DONE : B_LOAD;
      B_DONE: st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      out_valid_q <= 1'b0;
      front_q <= '0;
      rear_ang_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (st_q == B_DONE) out_valid_q <= 1'b1;
      // z holds the finished angle in B_LOAD or B_DONE, right after the last iteration
      if (st_q == B_LOAD && rear_q) front_q <= ang;
      if (st_q == B_DONE && job_q.fresh) rear_ang_q <= ang;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE: begin
        job_q <= job_i;
        rear_q <= 1'b0;
      end
      B_MUL: kb_q <= kprod >>> FracBits;
      B_LOAD: begin
        x_q <= W'(1) <<< GuardFrac;
        y_q <= W'(arg) <<< (GuardFrac - FracBits);
        z_q <= '0;
        i_q <= '0;
      end
      B_ITER: begin
        i_q <= i_q + IW'(1);
        if (!y_q[W-1]) begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + W'(atan_lut(i_q));
        end else begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - W'(atan_lut(i_q));
        end
        if (i_q == IW'(Steps - 1)) rear_q <= 1'b1;
      end
      B_DONE: begin
        out_q.speed_out    <= job_q.speed;
        out_q.front_angle  <= front_q;
        out_q.rear_angle   <= job_q.fresh ? ang : rear_ang_q;
        out_q.curv_clamped <= job_q.clamped;
        out_q.angles_fresh <= job_q.fresh;
      end
      default: ;
    endcase
  end

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_DONE) |-> !out_valid_q || out_ready_i) else $error("result overrun");
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_ITER) |-> (i_q < IW'(Steps))) else $error("cordic index");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_MUL && !job_q.fresh) |=> $stable(front_q) && $stable(rear_ang_q))
    else $error("held angle changed");

endmodule
`default_nettype wire

[hdl/four_wheel_steer_command_limiter.sv]
// ----------------------------------------------------------------------------
// four_wheel_steer_command_limiter: speed and steer limiter for 4ws drive
// front classifies and limits, back runs the cordic, short queue between
//
// channel  | handshake              | payload
// in       | in_valid_i/in_ready_o  | in_data_i  (cmd_in_t)
// out      | out_valid_o/out_ready_i| out_data_o (cmd_out_t)
// cfg      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// front: one command at a time, paced by the 27-step serial curvature divider
// back: two passes per job on one cordic unit, front angle then rear
// zero-speed commands skip divider and cordic
// a stalled result holds the back; the queue lets the front run ahead
// reset clears control and held angles; config regs reset to defaults
// ----------------------------------------------------------------------------
`default_nettype none
module four_wheel_steer_command_limiter #(
  parameter int FracBits    = fwsl_pkg::FracBitsDef,
  parameter int CordicSteps = fwsl_pkg::CordicStepsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fwsl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [fwsl_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire fwsl_pkg::cmd_in_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output fwsl_pkg::cmd_out_t                out_data_o
);
  import fwsl_pkg::*;

  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed   <= CfgW'(4096);
      cfg_q.floor_speed <= '0;
      cfg_q.incline     <= '0;
      cfg_q.tan_max     <= CfgW'(2365);
      cfg_q.half_base   <= CfgW'(655);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data_i;
        CFG_FLOOR_SPEED: cfg_q.floor_speed <= cfg_data_i;
        CFG_INCLINE:     cfg_q.incline     <= cfg_data_i;
        CFG_TAN_MAX:     cfg_q.tan_max     <= cfg_data_i;
        CFG_HALF_BASE:   cfg_q.half_base   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  fwsl_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  fwsl_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  fwsl_back #(.FracBits(FracBits), .CordicSteps(CordicSteps)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire

[bench/tb_four_wheel_steer_command_limiter.sv]
// ----------------------------------------------------------------------------
// tb_four_wheel_steer_command_limiter: self-checking bench of the steer limiter
// directed table then random commands over several register settings, results
// checked against a bit-true predictor with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_four_wheel_steer_command_limiter;
  import fwsl_pkg::*;

  localparam int Frac   = 12;
  localparam int Steps  = 14;
  localparam int Settle = 200;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_q = CFG_MAX_SPEED;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  cmd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cmd_out_t out_data_o;

  four_wheel_steer_command_limiter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_q),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // limiter registers and held angles as the block should have them
  longint   lim_max, lim_min, lim_incl, lim_tmax, lim_hb;
  longint   hold_front, hold_rear;
  cmd_out_t limited_q[$];
  int       errors = 0;
  int       send_idle = 0, recv_stall = 0;

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint steer_atan(longint arg);
    longint x, y, z, dx, dy;
    x = longint'(1) << GuardFrac;
    y = arg * (longint'(1) << (GuardFrac - Frac));
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
      end
    end
    z = shr_floor(z + (longint'(1) << (GuardFrac - Frac - 1)), GuardFrac - Frac);
    return clip16(z);
  endfunction

  function automatic cmd_out_t limit_command(cmd_in_t c);
    cmd_out_t r;
    longint s, incl, k, mag, im, kap, tg, hb, maxk, mt, kb;
    s = c.speed_req; incl = c.inclination;
    kap = c.curvature_req; tg = c.lateral_tan_req;
    k = (longint'(1) << Frac) - shr_floor(incl * lim_incl, Frac);
    mag = s < 0 ? -s : s;
    im = k <= 0 ? 0 : (mag * k) >>> Frac;
    if (s > 0) begin
      if (s > lim_max) s = lim_max;
      if (s > im) s = im;
      if (s < lim_min) s = lim_min;
    end else if (s < 0) begin
      if (s < -lim_max) s = -lim_max;
      if (s < -im) s = -im;
      if (s > -lim_min) s = -lim_min;
    end
    s = clip16(s);
    hb = lim_hb == 0 ? 1 : lim_hb;
    r = '0;
    if (s != 0) begin
      maxk = (lim_tmax << Frac) / hb;
      if (kap >= maxk) begin
        kap = maxk; tg = 0; r.curv_clamped = 1'b1;
      end else if (kap <= -maxk) begin
        kap = -maxk; tg = 0; r.curv_clamped = 1'b1;
      end else begin
        mag = kap < 0 ? -kap : kap;
        mt = lim_tmax - ((mag * hb) >>> Frac);
        if (tg > mt) tg = mt;
        if (tg < -mt) tg = -mt;
      end
      kb = shr_floor(kap * hb, Frac);
      hold_front = steer_atan(tg + kb);
      hold_rear = steer_atan(-tg + kb);
      r.angles_fresh = 1'b1;
    end
    r.speed_out = s[15:0];
    r.front_angle = hold_front[15:0];
    r.rear_angle = hold_rear[15:0];
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_q <= idx;
    cfg_data_i <= val[CfgW-1:0];
    case (idx)
      CFG_MAX_SPEED:   lim_max = val;
      CFG_FLOOR_SPEED: lim_min = val;
      CFG_INCLINE:     lim_incl = val;
      CFG_TAN_MAX:     lim_tmax = val;
      default:         lim_hb = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // valid stays up between back to back transfers unless a random idle gap is drawn
  task automatic send_cmd(cmd_in_t c);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    limited_q.push_back(limit_command(c));
  endtask

  // returns a signed 16-bit value biased toward edges and small magnitudes
  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'(16'h7FFF - $urandom_range(3));
      1: return 16'(16'h8000 + $urandom_range(3));
      2: return 16'($signed($urandom_range(8192)) - 4096);
      3: return 16'($signed($urandom_range(1000)) - 500);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cmd_in_t random_cmd();
    cmd_in_t c;
    c.speed_req = ($urandom_range(9) == 0) ? 16'sd0 : pick16();
    c.curvature_req = pick16();
    c.lateral_tan_req = pick16();
    c.inclination = ($urandom_range(2) == 0) ? 16'sd0 : pick16();
    return c;
  endfunction

  // directed rows: speed, curvature, tangent, inclination, typed result if known
  typedef struct {
    cmd_in_t  cmd;
    logic     typed;
    cmd_out_t want;
  } row_t;
  row_t rows[$];

  function automatic row_t mk(int s, int k, int t, int i);
    row_t r;
    r.cmd = {16'(s), 16'(k), 16'(t), 16'(i)};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // checker
  always @(posedge clk_i) begin
    cmd_out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (limited_q.size() == 0) begin
        $error("result transfer with none expected");
        errors++;
      end else begin
        w = limited_q.pop_front();
        if (out_data_o.speed_out !== w.speed_out) begin
          $error("speed_out exp %0d got %0d", w.speed_out, out_data_o.speed_out); errors++;
        end
        if (out_data_o.front_angle !== w.front_angle) begin
          $error("front_angle exp %0d got %0d", w.front_angle, out_data_o.front_angle);
          errors++;
        end
        if (out_data_o.rear_angle !== w.rear_angle) begin
          $error("rear_angle exp %0d got %0d", w.rear_angle, out_data_o.rear_angle); errors++;
        end
        if (out_data_o.curv_clamped !== w.curv_clamped) begin
          $error("curv_clamped exp %0b got %0b", w.curv_clamped, out_data_o.curv_clamped);
          errors++;
        end
        if (out_data_o.angles_fresh !== w.angles_fresh) begin
          $error("angles_fresh exp %0b got %0b", w.angles_fresh, out_data_o.angles_fresh);
          errors++;
        end
      end
    end
  end

  // receiver with random stall
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #3000000;
    $display("four_wheel_steer_command_limiter: mismatch");
    $finish;
  end

  initial begin
    row_t r;
    int   phase;
    lim_max = 4096; lim_min = 0; lim_incl = 0; lim_tmax = 2365; lim_hb = 655;
    hold_front = 0; hold_rear = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // zero speed right after reset holds zero angles
    r = mk(0, 1000, 500, 0); r.typed = 1'b1; rows.push_back(r);
    // max speed, straight: speed clipped to 4096
    rows.push_back(mk(32767, 0, 0, 0));
    rows.push_back(mk(-32768, 0, 0, 0));
    rows.push_back(mk(1000, 32767, 100, 0));
    rows.push_back(mk(1000, -32768, -100, 0));
    rows.push_back(mk(1000, 1000, 32767, 0));
    rows.push_back(mk(-1000, -1000, -32768, 0));
    rows.push_back(mk(2000, 0, 0, 32767));
    rows.push_back(mk(2000, 0, 0, -32768));
    rows.push_back(mk(0, -32768, 32767, -32768));
    rows.push_back(mk(1, 14000, 50, 0));
    rows.push_back(mk(-1, -14000, 50, 4096));
    rows.push_back(mk(4096, 14790, 0, 0));
    rows.push_back(mk(4096, -14790, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].typed) void'(limit_command(rows[i].cmd)); // keep held angles in step
      send_cmd(rows[i].cmd);
      if (rows[i].typed) begin
        void'(limited_q.pop_back());
        limited_q.push_back(rows[i].want);
      end
    end
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      case (phase)
        0: begin
          write_reg(CFG_MAX_SPEED, 32767); write_reg(CFG_FLOOR_SPEED, 0);
          write_reg(CFG_INCLINE, 0); write_reg(CFG_TAN_MAX, 32767);
          write_reg(CFG_HALF_BASE, 32767);
        end
        1: begin
          write_reg(CFG_MAX_SPEED, 0); write_reg(CFG_FLOOR_SPEED, 32767);
          write_reg(CFG_TAN_MAX, 0); write_reg(CFG_HALF_BASE, 1);
        end
        2: begin
          write_reg(CFG_HALF_BASE, 0); write_reg(CFG_INCLINE, 32767);
          write_reg(CFG_FLOOR_SPEED, 0); write_reg(CFG_MAX_SPEED, 8000);
        end
        default: begin
          write_reg(CFG_MAX_SPEED, $urandom_range(32767));
          write_reg(CFG_FLOOR_SPEED, $urandom_range(2000));
          write_reg(CFG_INCLINE, $urandom_range(8192));
          write_reg(CFG_TAN_MAX, $urandom_range(32767));
          write_reg(CFG_HALF_BASE, $urandom_range(1, 32767));
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        send_cmd(random_cmd());
        // let the pipe run dry once
        if (phase == 3 && n == 100) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (limited_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("four_wheel_steer_command_limiter: match");
    end else begin
      $display("four_wheel_steer_command_limiter: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/fwsl_pkg.sv
hdl/fwsl_front.sv
hdl/fwsl_queue.sv
hdl/fwsl_back.sv
hdl/four_wheel_steer_command_limiter.sv
bench/tb_four_wheel_steer_command_limiter.sv
